[design/arp_rr_pkg.sv]
// Shared types and constants for the ARP resolver and responder.
// Used by arp_rr_table, arp_rr_ctrl and arp_resolver_responder_top; no dependencies.
package arp_rr_pkg;

    localparam logic [1:0] OP_SEND_IP  = 2'd0;
    localparam logic [1:0] OP_RX_IP    = 2'd1;
    localparam logic [1:0] OP_RX_ARP   = 2'd2;
    localparam logic [1:0] OP_RX_OTHER = 2'd3;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_SEND_IP   = 3'd1;
    localparam logic [2:0] ACT_ARP_REQ   = 3'd2;
    localparam logic [2:0] ACT_ARP_REPLY = 3'd3;
    localparam logic [2:0] ACT_DELIVER   = 3'd4;
    localparam logic [2:0] ACT_ERROR     = 3'd5;

    localparam logic [1:0] ARP_OP_REQUEST = 2'd1;
    localparam logic [1:0] ARP_OP_REPLY   = 2'd2;
    localparam logic [7:0] ARP_OP_REPLY_BYTE = 8'd2;

    localparam logic [15:0] TYPE_IP  = 16'h0800;
    localparam logic [15:0] TYPE_ARP = 16'h0806;
    localparam logic [6:0]  ARP_BODY_LEN = 7'd28;
    localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

    localparam logic REG_MY_IP  = 1'b0;
    localparam logic REG_MY_MAC = 1'b1;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } entry_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ip;
        logic [47:0] mac;
    } tbl_rsp_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } tbl_ctl_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] dest_mac;
        logic [15:0] ether_type;
        logic [6:0]  out_length;
        logic [1:0]  out_arp_operation;
        logic [47:0] out_sender_mac;
        logic [31:0] out_sender_ip;
        logic [47:0] out_target_mac;
        logic [31:0] out_target_ip;
    } result_t;

endpackage

[design/arp_rr_table.sv]
// Binding table: synchronous IP/MAC memory with a registered read,
// plus per-entry valid flags cleared at reset. Depends on arp_rr_pkg.
module arp_rr_table #(
    parameter int TABLE_ENTRIES = 8,
    parameter int IDX_W = 3
) (
    input  logic                clk,
    input  logic                rst_n,
    input  arp_rr_pkg::tbl_ctl_t ctl,
    input  logic [IDX_W-1:0]    rd_addr,
    input  logic [IDX_W-1:0]    wr_addr,
    input  arp_rr_pkg::entry_t  wr_entry,
    output arp_rr_pkg::tbl_rsp_t rsp
);

    arp_rr_pkg::entry_t mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    arp_rr_pkg::entry_t rd_data_reg;
    logic rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rsp.valid = rd_valid_reg;
    assign rsp.ip    = rd_data_reg.ip;
    assign rsp.mac   = rd_data_reg.mac;

endmodule

[design/arp_rr_ctrl.sv]
// Sequencer: captures a request beat, scans or updates the binding table,
// forms the result and holds it in the output register. Depends on arp_rr_pkg.
module arp_rr_ctrl #(
    parameter int TABLE_ENTRIES = 8,
    parameter int IDX_W = 3,
    parameter int CNT_W = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic [1:0]           opcode,
    input  logic [31:0]          target_ip,
    input  logic [47:0]          sender_mac,
    input  logic [31:0]          sender_ip,
    input  logic [7:0]           arp_operation,
    input  logic [6:0]           frame_length,
    input  logic [31:0]          my_ip,
    input  logic [47:0]          my_mac,
    output arp_rr_pkg::tbl_ctl_t tbl_ctl,
    output logic [IDX_W-1:0]     tbl_rd_addr,
    output logic [IDX_W-1:0]     tbl_wr_addr,
    output arp_rr_pkg::entry_t   tbl_wr_entry,
    input  arp_rr_pkg::tbl_rsp_t tbl_rsp,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output arp_rr_pkg::result_t  rsp_result
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_ENTRIES - 1);

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] iss_reg, iss_next;
    logic             chk_vld_reg, chk_vld_next;
    logic             chk_last_reg, chk_last_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic             hit_reg, hit_next;
    logic [47:0]      mac_reg, mac_next;
    logic             rsp_valid_reg, rsp_valid_next;
    arp_rr_pkg::result_t rsp_result_reg, result_now;

    logic [1:0]  op_reg;
    logic [31:0] tip_reg;
    logic [47:0] smac_reg;
    logic [31:0] sip_reg;
    logic [7:0]  aop_reg;
    logic [6:0]  flen_reg;

    logic accept;
    logic learn;
    logic rd_en;
    logic match;
    logic scan_done;
    logic emit_load;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign learn     = accept && (opcode == arp_rr_pkg::OP_RX_ARP)
                       && (frame_length >= arp_rr_pkg::ARP_BODY_LEN)
                       && (target_ip == my_ip);
    assign rd_en     = (state_reg == S_SCAN) && (iss_reg != CNT_END);
    assign match     = chk_vld_reg && tbl_rsp.valid && (tbl_rsp.ip == tip_reg);
    assign scan_done = match || (chk_vld_reg && chk_last_reg);
    assign emit_load = (state_reg == S_EMIT) && (!rsp_valid_reg || rsp_ready);

    assign tbl_ctl.rd_en = rd_en;
    assign tbl_ctl.wr_en = learn;
    assign tbl_rd_addr   = iss_reg[IDX_W-1:0];
    assign tbl_wr_addr   = ptr_reg;
    assign tbl_wr_entry.ip  = sender_ip;
    assign tbl_wr_entry.mac = sender_mac;

    always_comb
    begin
        state_next     = state_reg;
        iss_next       = iss_reg;
        chk_vld_next   = 1'b0;
        chk_last_next  = 1'b0;
        ptr_next       = ptr_reg;
        hit_next       = hit_reg;
        mac_next       = mac_reg;
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    iss_next = '0;
                    hit_next = 1'b0;
                    state_next = (opcode == arp_rr_pkg::OP_SEND_IP) ? S_SCAN : S_EMIT;
                end
                if (learn)
                begin
                    ptr_next = (ptr_reg == IDX_LAST) ? '0 : ptr_reg + 1'b1;
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    iss_next = iss_reg + 1'b1;
                end
                chk_vld_next  = rd_en && !scan_done;
                chk_last_next = rd_en && (iss_reg == CNT_LAST);
                if (chk_vld_reg && !tbl_rsp.valid && iss_reg == CNT_END && !chk_last_reg)
                begin
                    state_next = S_SCAN;
                end
                if (scan_done)
                begin
                    hit_next   = match;
                    mac_next   = tbl_rsp.mac;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (emit_load)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_now = '0;
        unique case (op_reg)
            arp_rr_pkg::OP_SEND_IP:
            begin
                if (hit_reg)
                begin
                    result_now.action     = arp_rr_pkg::ACT_SEND_IP;
                    result_now.dest_mac   = mac_reg;
                    result_now.ether_type = arp_rr_pkg::TYPE_IP;
                    result_now.out_length = flen_reg;
                end
                else
                begin
                    result_now.action            = arp_rr_pkg::ACT_ARP_REQ;
                    result_now.dest_mac          = arp_rr_pkg::BCAST_MAC;
                    result_now.ether_type        = arp_rr_pkg::TYPE_ARP;
                    result_now.out_length        = arp_rr_pkg::ARP_BODY_LEN;
                    result_now.out_arp_operation = arp_rr_pkg::ARP_OP_REQUEST;
                    result_now.out_sender_mac    = my_mac;
                    result_now.out_sender_ip     = my_ip;
                    result_now.out_target_mac    = arp_rr_pkg::BCAST_MAC;
                    result_now.out_target_ip     = tip_reg;
                end
            end
            arp_rr_pkg::OP_RX_IP:
            begin
                result_now.action     = arp_rr_pkg::ACT_DELIVER;
                result_now.ether_type = arp_rr_pkg::TYPE_IP;
                result_now.out_length = flen_reg;
            end
            arp_rr_pkg::OP_RX_ARP:
            begin
                if (flen_reg < arp_rr_pkg::ARP_BODY_LEN)
                begin
                    result_now.action = arp_rr_pkg::ACT_ERROR;
                end
                else if (tip_reg == my_ip && aop_reg != arp_rr_pkg::ARP_OP_REPLY_BYTE)
                begin
                    result_now.action            = arp_rr_pkg::ACT_ARP_REPLY;
                    result_now.dest_mac          = smac_reg;
                    result_now.ether_type        = arp_rr_pkg::TYPE_ARP;
                    result_now.out_length        = flen_reg;
                    result_now.out_arp_operation = arp_rr_pkg::ARP_OP_REPLY;
                    result_now.out_sender_mac    = my_mac;
                    result_now.out_sender_ip     = my_ip;
                    result_now.out_target_mac    = smac_reg;
                    result_now.out_target_ip     = sip_reg;
                end
            end
            arp_rr_pkg::OP_RX_OTHER:
            begin
                result_now.action = arp_rr_pkg::ACT_ERROR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iss_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            chk_last_reg  <= 1'b0;
            ptr_reg       <= '0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            chk_vld_reg   <= chk_vld_next;
            chk_last_reg  <= chk_last_next;
            ptr_reg       <= ptr_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mac_reg <= mac_next;
        if (accept)
        begin
            op_reg   <= opcode;
            tip_reg  <= target_ip;
            smac_reg <= sender_mac;
            sip_reg  <= sender_ip;
            aop_reg  <= arp_operation;
            flen_reg <= frame_length;
        end
        if (emit_load)
        begin
            rsp_result_reg <= result_now;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign rsp_result = rsp_result_reg;

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= IDX_LAST)
        else $error("insert pointer beyond table");

    a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_ctl.wr_en |-> (state_reg == S_IDLE && req_valid))
        else $error("table written outside request acceptance");

    a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(tbl_ctl.rd_en && tbl_ctl.wr_en))
        else $error("table read and write in the same cycle");

    a_check_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        chk_vld_reg |-> (state_reg == S_SCAN))
        else $error("table data checked outside a scan");

    a_emit_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result shown without passing through emit");

endmodule

[design/arp_resolver_responder_top.sv]
// Top level of the ARP resolver and responder: configuration registers,
// binding table and sequencer. Depends on arp_rr_pkg, arp_rr_table, arp_rr_ctrl.
//
//  Channel  Handshake              Payload
//  req      req_valid/req_ready    opcode, target_ip, sender_mac, sender_ip,
//                                  arp_operation, frame_length
//  rsp      rsp_valid/rsp_ready    action, dest_mac, ether_type, out_length,
//                                  out_arp_operation, out_sender_*, out_target_*
//  cfg      cfg_we (no stall)      cfg_index, cfg_data
//
// A send beat scans the table one entry per cycle through the memory read port,
// stopping at the first hit and reading at most TABLE_ENTRIES entries. Every
// other beat skips the scan. Reset clears the valid flags, insert pointer,
// control state and configuration registers at once; no clearing pass is needed.
// A new beat is accepted while a finished result waits in the output register.
module arp_resolver_responder_top #(
    parameter int TABLE_ENTRIES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  opcode,
    input  logic [31:0] target_ip,
    input  logic [47:0] sender_mac,
    input  logic [31:0] sender_ip,
    input  logic [7:0]  arp_operation,
    input  logic [6:0]  frame_length,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  action,
    output logic [47:0] dest_mac,
    output logic [15:0] ether_type,
    output logic [6:0]  out_length,
    output logic [1:0]  out_arp_operation,
    output logic [47:0] out_sender_mac,
    output logic [31:0] out_sender_ip,
    output logic [47:0] out_target_mac,
    output logic [31:0] out_target_ip
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    logic [31:0] my_ip_reg;
    logic [47:0] my_mac_reg;

    arp_rr_pkg::tbl_ctl_t tbl_ctl;
    arp_rr_pkg::entry_t   tbl_wr_entry;
    arp_rr_pkg::tbl_rsp_t tbl_rsp;
    arp_rr_pkg::result_t  result;
    logic [IDX_W-1:0]     tbl_rd_addr;
    logic [IDX_W-1:0]     tbl_wr_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_ip_reg  <= '0;
            my_mac_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                arp_rr_pkg::REG_MY_IP:  my_ip_reg  <= cfg_data[31:0];
                arp_rr_pkg::REG_MY_MAC: my_mac_reg <= cfg_data;
            endcase
        end
    end

    arp_rr_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (tbl_ctl),
        .rd_addr  (tbl_rd_addr),
        .wr_addr  (tbl_wr_addr),
        .wr_entry (tbl_wr_entry),
        .rsp      (tbl_rsp)
    );

    arp_rr_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .IDX_W         (IDX_W),
        .CNT_W         (CNT_W)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .opcode        (opcode),
        .target_ip     (target_ip),
        .sender_mac    (sender_mac),
        .sender_ip     (sender_ip),
        .arp_operation (arp_operation),
        .frame_length  (frame_length),
        .my_ip         (my_ip_reg),
        .my_mac        (my_mac_reg),
        .tbl_ctl       (tbl_ctl),
        .tbl_rd_addr   (tbl_rd_addr),
        .tbl_wr_addr   (tbl_wr_addr),
        .tbl_wr_entry  (tbl_wr_entry),
        .tbl_rsp       (tbl_rsp),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .rsp_result    (result)
    );

    assign action            = result.action;
    assign dest_mac          = result.dest_mac;
    assign ether_type        = result.ether_type;
    assign out_length        = result.out_length;
    assign out_arp_operation = result.out_arp_operation;
    assign out_sender_mac    = result.out_sender_mac;
    assign out_sender_ip     = result.out_sender_ip;
    assign out_target_mac    = result.out_target_mac;
    assign out_target_ip     = result.out_target_ip;

endmodule
